### src/spf_pkg.sv
package spf_pkg;

  // Field and datapath widths
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SH_W       = 30;
  localparam int SQ_W       = 2 * SH_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SHIFT_W    = 2;
  localparam int DIST_W     = ROOT_W + 3;
  localparam int REST_W     = 32;
  localparam int MAG_W      = DIST_W;
  localparam int FRAC_W     = 30;
  localparam int QUO_W      = FRAC_W + 1;
  localparam int DREM_W     = ROOT_W + FRAC_W;
  localparam int FORCE_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int SCALE_W    = 8;
  localparam int WEIGHT_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LANES      = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTRACT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEL   = 2'd2;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST    = 16'd13107;
  localparam logic [SCALE_W-1:0] ATTRACT_RST = 8'd20;
  localparam logic [SCALE_W-1:0] REPEL_RST   = 8'd40;

  // Sideband carried through the square root
  typedef struct packed {
    logic                            mode;
    logic [LANES-1:0]                dneg;
    logic [SHIFT_W-1:0]              shift;
    logic [REST_W-1:0]               rest;
    logic [LANES-1:0][SH_W-1:0]      dsh;
  } sqrt_side_t;

  // Sideband carried through the divider
  typedef struct packed {
    logic [LANES-1:0]   dneg;
    logic               mneg;
    logic               applied;
    logic               zero;
    logic [MAG_W-1:0]   mag;
  } div_side_t;

endpackage

### src/spf_isqrt.sv
module spf_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [spf_pkg::SUM_W-1:0] radicand,
  input  spf_pkg::sqrt_side_t       in_side,
  output logic                      out_valid,
  output logic [spf_pkg::ROOT_W-1:0] root,
  output spf_pkg::sqrt_side_t       out_side
);
  import spf_pkg::*;

  logic              vld  [ROOT_W];
  logic [SUM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] quo  [ROOT_W];
  sqrt_side_t        side [ROOT_W];

  // One root bit per stage, most significant first
  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    localparam int K = ROOT_W - 1 - g;
    logic              pv;
    logic [SUM_W-1:0]  prem;
    logic [ROOT_W-1:0] pq;
    sqrt_side_t        pside;
    logic [SUM_W:0]    trial;
    logic              take;

    if (g == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = radicand;
      assign pq    = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[g-1];
      assign prem  = rem[g-1];
      assign pq    = quo[g-1];
      assign pside = side[g-1];
    end

    // Trial subtrahend (4q+1) * 4^k
    assign trial = (SUM_W+1)'({pq, 2'b01}) << (2 * K);
    assign take  = {1'b0, prem} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= take ? SUM_W'({1'b0, prem} - trial) : prem;
        quo[g]  <= {pq[ROOT_W-2:0], take};
        side[g] <= pside;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = quo[ROOT_W-1];
  assign out_side  = side[ROOT_W-1];

endmodule

### src/spf_div.sv
module spf_div (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  logic [spf_pkg::LANES-1:0][spf_pkg::SH_W-1:0]    dsh,
  input  logic [spf_pkg::ROOT_W-1:0]                      divisor,
  input  spf_pkg::div_side_t                              in_side,
  output logic                                            out_valid,
  output logic [spf_pkg::LANES-1:0][spf_pkg::QUO_W-1:0]   quotient,
  output spf_pkg::div_side_t                              out_side
);
  import spf_pkg::*;

  logic                          vld  [QUO_W];
  logic [LANES-1:0][DREM_W-1:0]  rem  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]   quo  [QUO_W];
  logic [ROOT_W-1:0]             dvs  [QUO_W];
  div_side_t                     side [QUO_W];

  // One quotient bit per stage for all three lanes
  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    localparam int K = QUO_W - 1 - g;
    logic                          pv;
    logic [LANES-1:0][DREM_W-1:0]  prem;
    logic [LANES-1:0][QUO_W-1:0]   pq;
    logic [ROOT_W-1:0]             pd;
    div_side_t                     pside;
    logic [DREM_W-1:0]             trial;
    logic [LANES-1:0][DREM_W-1:0]  nrem;
    logic [LANES-1:0][QUO_W-1:0]   nq;

    if (g == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign prem[l] = DREM_W'({dsh[l], FRAC_W'(0)});
      end
      assign pv    = in_valid;
      assign pq    = '0;
      assign pd    = divisor;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[g-1];
      assign prem  = rem[g-1];
      assign pq    = quo[g-1];
      assign pd    = dvs[g-1];
      assign pside = side[g-1];
    end

    assign trial = DREM_W'(pd) << K;

    // Compare and subtract per lane
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (prem[l] >= trial) begin
          nrem[l] = prem[l] - trial;
          nq[l]   = {pq[l][QUO_W-2:0], 1'b1};
        end else begin
          nrem[l] = prem[l];
          nq[l]   = {pq[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= nrem;
        quo[g]  <= nq;
        dvs[g]  <= pd;
        side[g] <= pside;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quotient  = quo[QUO_W-1];
  assign out_side  = side[QUO_W-1];

endmodule

### src/spring_pair_force_top.sv
// Spring force between two nodes of a 3D force-directed layout.
// Input channel (in_valid / in_stall): one node pair per item, positions a and b
// in signed Q16.16, the two link weights and mode (0 attract, 1 repel).
// Output channel (out_valid / out_stall): the force on each node, saturated to
// 32 bits, force on b the exact negation of force on a, plus the applied flag.
// Configuration: cfg_we / cfg_index / cfg_data write spring_gain (0),
// attract_scale (1), repel_scale (2); other indexes are ignored. Write only
// while no item is in flight.
// Throughput: one item per cycle while out_stall does not hold a waiting result.
// The square-root pipeline and the three-lane divider have 31 stages each, one
// result bit per stage.
// Reset clears all valid bits and loads the register defaults.
// When out_stall is high with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
module spring_pair_force_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [spf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [spf_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic signed [spf_pkg::COORD_W-1:0]    a_x,
  input  logic signed [spf_pkg::COORD_W-1:0]    a_y,
  input  logic signed [spf_pkg::COORD_W-1:0]    a_z,
  input  logic signed [spf_pkg::COORD_W-1:0]    b_x,
  input  logic signed [spf_pkg::COORD_W-1:0]    b_y,
  input  logic signed [spf_pkg::COORD_W-1:0]    b_z,
  input  logic [spf_pkg::WEIGHT_W-1:0]          weight_a,
  input  logic [spf_pkg::WEIGHT_W-1:0]          weight_b,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [spf_pkg::FORCE_W-1:0]    force_a_x,
  output logic signed [spf_pkg::FORCE_W-1:0]    force_a_y,
  output logic signed [spf_pkg::FORCE_W-1:0]    force_a_z,
  output logic signed [spf_pkg::FORCE_W-1:0]    force_b_x,
  output logic signed [spf_pkg::FORCE_W-1:0]    force_b_y,
  output logic signed [spf_pkg::FORCE_W-1:0]    force_b_z,
  output logic                                  applied
);
  import spf_pkg::*;

  logic [GAIN_W-1:0]  spring_gain;
  logic [SCALE_W-1:0] attract_scale;
  logic [SCALE_W-1:0] repel_scale;
  logic               en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spring_gain   <= GAIN_RST;
      attract_scale <= ATTRACT_RST;
      repel_scale   <= REPEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:    spring_gain   <= cfg_data;
        REG_ATTRACT: attract_scale <= cfg_data[SCALE_W-1:0];
        REG_REPEL:   repel_scale   <= cfg_data[SCALE_W-1:0];
        default:     ;
      endcase
    end
  end

  // Advance the whole pipeline unless a result waits on a stalled receiver
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: differences, magnitudes and rest distance
  logic signed [COORD_W-1:0]     pa [LANES];
  logic signed [COORD_W-1:0]     pb [LANES];
  logic [LANES-1:0]              dneg1;
  logic [LANES-1:0][DIFF_W-1:0]  dm1;
  logic signed [DIFF_W-1:0]      dd [LANES];
  logic [SCALE_W-1:0]            scale;
  logic [SCALE_W+WEIGHT_W:0]     rprod;
  logic                          s1_valid;
  logic                          s1_mode;
  logic [LANES-1:0]              s1_dneg;
  logic [LANES-1:0][DIFF_W-1:0]  s1_dm;
  logic [REST_W-1:0]             s1_rest;

  assign pa[0] = a_x;
  assign pa[1] = a_y;
  assign pa[2] = a_z;
  assign pb[0] = b_x;
  assign pb[1] = b_y;
  assign pb[2] = b_z;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      dd[i]    = DIFF_W'(pa[i]) - DIFF_W'(pb[i]);
      dneg1[i] = dd[i][DIFF_W-1];
      dm1[i]   = dneg1[i] ? DIFF_W'(-dd[i]) : DIFF_W'(dd[i]);
    end
  end

  assign scale = mode ? repel_scale : attract_scale;
  assign rprod = (SCALE_W+WEIGHT_W+1)'(scale)
               * ((SCALE_W+WEIGHT_W+1)'(weight_a) + (SCALE_W+WEIGHT_W+1)'(weight_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode <= mode;
      s1_dneg <= dneg1;
      s1_dm   <= dm1;
      s1_rest <= {rprod[REST_W-16:0], 15'd0};
    end
  end

  // Stage 2: normalize so that every magnitude fits 30 bits
  logic [DIFF_W-1:0]   maxm;
  logic [SHIFT_W-1:0]  sh2;
  logic                s2_valid;
  sqrt_side_t          s2_side;

  always_comb begin
    maxm = s1_dm[0];
    if (s1_dm[1] > maxm) maxm = s1_dm[1];
    if (s1_dm[2] > maxm) maxm = s1_dm[2];
    if (maxm[DIFF_W-1])      sh2 = 2'd3;
    else if (maxm[DIFF_W-2]) sh2 = 2'd2;
    else if (maxm[DIFF_W-3]) sh2 = 2'd1;
    else                     sh2 = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side.mode  <= s1_mode;
      s2_side.dneg  <= s1_dneg;
      s2_side.shift <= sh2;
      s2_side.rest  <= s1_rest;
      for (int i = 0; i < LANES; i++) begin
        s2_side.dsh[i] <= SH_W'(s1_dm[i] >> sh2);
      end
    end
  end

  // Stage 3: squares
  logic                        s3_valid;
  logic [LANES-1:0][SQ_W-1:0]  s3_sq;
  sqrt_side_t                  s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        s3_sq[i] <= SQ_W'(s2_side.dsh[i]) * SQ_W'(s2_side.dsh[i]);
      end
      s3_side <= s2_side;
    end
  end

  // Stage 4: sum of squares
  logic               s4_valid;
  logic [SUM_W-1:0]   s4_sum;
  sqrt_side_t         s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sum  <= SUM_W'(s3_sq[0]) + SUM_W'(s3_sq[1]) + SUM_W'(s3_sq[2]);
      s4_side <= s3_side;
    end
  end

  // Square root pipeline
  logic               sq_valid;
  logic [ROOT_W-1:0]  sq_root;
  sqrt_side_t         sq_side;

  spf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s4_valid),
    .radicand (s4_sum),
    .in_side  (s4_side),
    .out_valid(sq_valid),
    .root     (sq_root),
    .out_side (sq_side)
  );

  // Post stage 1: distance against rest distance
  logic [DIST_W-1:0]           span;
  logic                        far;
  logic                        p1_valid;
  logic [LANES-1:0][SH_W-1:0]  p1_dsh;
  logic [LANES-1:0]            p1_dneg;
  logic [ROOT_W-1:0]           p1_root;
  logic                        p1_mneg;
  logic                        p1_applied;
  logic                        p1_zero;
  logic [DIST_W-1:0]           p1_diff;

  assign span = DIST_W'(sq_root) << sq_side.shift;
  assign far  = span > DIST_W'(sq_side.rest);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_dsh     <= sq_side.dsh;
      p1_dneg    <= sq_side.dneg;
      p1_root    <= sq_root;
      p1_mneg    <= far;
      p1_applied <= !(sq_side.mode && far);
      p1_zero    <= sq_root == '0;
      p1_diff    <= far ? span - DIST_W'(sq_side.rest) : DIST_W'(sq_side.rest) - span;
    end
  end

  // Post stage 2: force magnitude
  logic [DIST_W+GAIN_W-1:0]    mprod;
  logic                        p2_valid;
  logic [LANES-1:0][SH_W-1:0]  p2_dsh;
  logic [ROOT_W-1:0]           p2_root;
  div_side_t                   p2_side;

  assign mprod = (DIST_W+GAIN_W)'(p1_diff) * (DIST_W+GAIN_W)'(spring_gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_dsh          <= p1_dsh;
      p2_root         <= p1_root;
      p2_side.dneg    <= p1_dneg;
      p2_side.mneg    <= p1_mneg;
      p2_side.applied <= p1_applied;
      p2_side.zero    <= p1_zero;
      p2_side.mag     <= MAG_W'(mprod >> GAIN_W);
    end
  end

  // Unit normal, three lanes
  logic                         dv_valid;
  logic [LANES-1:0][QUO_W-1:0]  dv_quo;
  div_side_t                    dv_side;

  spf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p2_valid),
    .dsh      (p2_dsh),
    .divisor  (p2_root),
    .in_side  (p2_side),
    .out_valid(dv_valid),
    .quotient (dv_quo),
    .out_side (dv_side)
  );

  // Final stage 1: partial products of magnitude times normal
  localparam int PH_W = MAG_W - FRAC_W + QUO_W;
  localparam int PL_W = FRAC_W + QUO_W;
  logic                         f1_valid;
  logic [LANES-1:0][PH_W-1:0]   f1_ph;
  logic [LANES-1:0][PL_W-1:0]   f1_pl;
  div_side_t                    f1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        f1_ph[i] <= PH_W'(dv_side.mag[MAG_W-1:FRAC_W]) * PH_W'(dv_quo[i]);
        f1_pl[i] <= PL_W'(dv_side.mag[FRAC_W-1:0]) * PL_W'(dv_quo[i]);
      end
      f1_side <= dv_side;
    end
  end

  // Final stage 2: sum, saturate, sign and output register
  logic [PH_W:0]               fsum [LANES];
  logic [FORCE_W-1:0]          fmag [LANES];
  logic [FORCE_W-1:0]          fa   [LANES];
  logic [FORCE_W-1:0]          fb   [LANES];
  logic                        neg;

  always_comb begin
    neg = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      fsum[i] = (PH_W+1)'(f1_ph[i]) + (PH_W+1)'(f1_pl[i] >> FRAC_W);
      if (fsum[i] > (PH_W+1)'({1'b0, {(FORCE_W-1){1'b1}}})) begin
        fmag[i] = {1'b0, {(FORCE_W-1){1'b1}}};
      end else begin
        fmag[i] = FORCE_W'(fsum[i]);
      end
      if (!f1_side.applied || f1_side.zero) begin
        fmag[i] = '0;
      end
      neg   = f1_side.mneg ^ f1_side.dneg[i];
      fa[i] = neg ? -fmag[i] : fmag[i];
      fb[i] = neg ? fmag[i] : -fmag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_a_x <= fa[0];
      force_a_y <= fa[1];
      force_a_z <= fa[2];
      force_b_x <= fb[0];
      force_b_y <= fb[1];
      force_b_z <= fb[2];
      applied   <= f1_side.applied;
    end
  end

endmodule
